[src/cbam_pkg.sv]
// shared types and constants for the chord button action mapper
`timescale 1ns / 1ps

package cbam_pkg;

  // table geometry
  localparam int NumActions = 23;
  localparam int NumButtons = 16;
  localparam int AddrW      = $clog2(NumActions);

  // command codes
  typedef enum logic [1:0] {
    CMD_EVAL      = 2'd0,
    CMD_BIND_MASK = 2'd1,
    CMD_BIND_SLOT = 2'd2
  } cmd_e;

  // status codes
  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_RANGE  = 2'd1,
    STS_SINGLE = 2'd2
  } status_e;

  // input item
  typedef struct packed {
    logic [1:0]            command;
    logic [4:0]            action_index;
    logic [NumButtons-1:0] pressed;
    logic [NumButtons-1:0] suppressed_mask;
    logic [NumButtons-1:0] new_mask;
    logic                  slot_select;
    logic [NumButtons-1:0] slot_button;
    logic [NumButtons-1:0] slot_modifier;
  } cbam_in_t;

  // result item
  typedef struct packed {
    logic [NumActions-1:0] action_mask;
    logic [NumButtons-1:0] chord_mask;
    logic [1:0]            status;
  } cbam_out_t;

  // one table entry: mask, two slot buttons, two slot modifiers
  typedef struct packed {
    logic [NumButtons-1:0] bound;
    logic [NumButtons-1:0] prim;
    logic [NumButtons-1:0] sec;
    logic [NumButtons-1:0] mod0;
    logic [NumButtons-1:0] mod1;
  } cbam_entry_t;

  // per-action evaluation results
  typedef struct packed {
    logic                  chord_fire;
    logic [NumButtons-1:0] used;
    logic [NumButtons-1:0] mods;
    logic [NumButtons-1:0] chords;
    logic                  plain_fire;
  } cbam_eval_t;

endpackage

[src/cbam_table.sv]
// binding table: one entry per action, cleared by reset
`timescale 1ns / 1ps

module cbam_table import cbam_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [AddrW-1:0]  addr_i,
  input  cbam_entry_t       wdata_i,
  output cbam_entry_t       rdata_o
);

  cbam_entry_t mem_q [NumActions];

  // single shared address for read and write
  assign rdata_o = mem_q[addr_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumActions; i++) begin
        mem_q[i] <= '0;
      end
    end else if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

endmodule

[src/cbam_eval_unit.sv]
// shared evaluation unit: chord and plain checks for one action entry
`timescale 1ns / 1ps

module cbam_eval_unit import cbam_pkg::*; (
  input  cbam_entry_t           entry_i,
  input  logic [NumButtons-1:0] pressed_i,
  input  logic [NumButtons-1:0] avail_i,
  output cbam_eval_t            result_o
);

  logic [NumButtons-1:0] both0, both1, plain;
  logic                  held0, held1;

  assign both0 = entry_i.mod0 | entry_i.prim;
  assign both1 = entry_i.mod1 | entry_i.sec;
  assign held0 = (entry_i.mod0 != '0) && ((pressed_i & both0) == both0);
  assign held1 = (entry_i.mod1 != '0) && ((pressed_i & both1) == both1);

  // plain set: mask less slot buttons, plus slot buttons with no modifier
  always_comb begin
    plain = entry_i.bound & ~(entry_i.prim | entry_i.sec);
    if (entry_i.mod0 == '0) plain = plain | entry_i.prim;
    if (entry_i.mod1 == '0) plain = plain | entry_i.sec;
  end

  // chord pass and plain pass outputs
  always_comb begin
    result_o.mods       = entry_i.mod0 | entry_i.mod1;
    result_o.used       = '0;
    result_o.chord_fire = 1'b0;
    result_o.chords     = '0;
    if (held0 && entry_i.prim != '0) begin
      result_o.chord_fire = 1'b1;
      result_o.used       = result_o.used | both0;
    end
    if (held1 && entry_i.sec != '0) begin
      result_o.chord_fire = 1'b1;
      result_o.used       = result_o.used | both1;
    end
    if (held0) result_o.chords = result_o.chords | both0;
    if (held1) result_o.chords = result_o.chords | both1;
    result_o.plain_fire = (avail_i & plain) != '0;
  end

endmodule

[src/chord_button_action_mapper.sv]
// top level: command sequencer, bind logic and result register
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o | in_data_i  (cbam_in_t)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (cbam_out_t)
//
// evaluate: the shared evaluation unit walks the table once for chords and once
// for plain bindings, one action a cycle, then loads the result.
// bind commands: accept, one read-modify-write of the entry, load.
// reset clears the whole table at once and leaves the block idle and empty.
// in_stall_o is high while a command is in work; a new command may be taken
// while the last result still waits in the output register under out_stall_i.
`timescale 1ns / 1ps

module chord_button_action_mapper import cbam_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  cbam_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output cbam_out_t out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHORD,
    ST_PLAIN,
    ST_BIND,
    ST_FINISH
  } state_e;

  localparam logic [AddrW-1:0] AddrLast = AddrW'(NumActions - 1);

  state_e                state_q, state_d;
  cbam_in_t              item_q, item_d;
  logic [AddrW-1:0]      addr_q, addr_d;
  logic [NumButtons-1:0] mods_q, mods_d;
  logic [NumButtons-1:0] used_q, used_d;
  logic [NumButtons-1:0] chords_q, chords_d;
  logic [NumActions-1:0] fired_q, fired_d;
  status_e               status_q, status_d;
  cbam_out_t             out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  cbam_entry_t           rd_entry, wr_entry;
  logic                  tbl_we;
  cbam_eval_t            ev;
  logic [NumButtons-1:0] avail;
  logic                  in_xfer;

  // one-hot or zero check
  function automatic logic is_single(logic [NumButtons-1:0] v);
    return (v & (v - 1'b1)) == '0;
  endfunction

  cbam_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tbl_we),
    .addr_i  (addr_q),
    .wdata_i (wr_entry),
    .rdata_o (rd_entry)
  );

  assign avail = item_q.pressed & ~(mods_q | used_q | item_q.suppressed_mask);

  cbam_eval_unit u_eval (
    .entry_i   (rd_entry),
    .pressed_i (item_q.pressed),
    .avail_i   (avail),
    .result_o  (ev)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // bind: new entry contents
  always_comb begin
    logic [NumButtons-1:0] low, rest, old, newmod;
    low      = '0;
    rest     = '0;
    old      = '0;
    newmod   = '0;
    wr_entry = rd_entry;
    tbl_we   = 1'b0;
    if (state_q == ST_BIND) begin
      unique case (item_q.command)
        CMD_BIND_MASK: begin
          low           = item_q.new_mask & (~item_q.new_mask + 1'b1);
          rest          = item_q.new_mask & ~low;
          wr_entry      = '0;
          wr_entry.bound = item_q.new_mask;
          wr_entry.prim = low;
          wr_entry.sec  = rest & (~rest + 1'b1);
          tbl_we        = 1'b1;
        end
        CMD_BIND_SLOT: begin
          if (is_single(item_q.slot_button) && is_single(item_q.slot_modifier) &&
              !(item_q.slot_button != '0 && item_q.slot_button == item_q.slot_modifier)) begin
            newmod = (item_q.slot_button == '0) ? '0 : item_q.slot_modifier;
            if (!item_q.slot_select) begin
              old           = rd_entry.prim;
              wr_entry.prim = item_q.slot_button;
              wr_entry.mod0 = newmod;
            end else begin
              old           = rd_entry.sec;
              wr_entry.sec  = item_q.slot_button;
              wr_entry.mod1 = newmod;
            end
            wr_entry.bound = (rd_entry.bound & ~old) | wr_entry.prim | wr_entry.sec;
            tbl_we         = 1'b1;
          end
        end
        default: begin
          tbl_we = 1'b0;
        end
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    addr_d      = addr_q;
    mods_d      = mods_q;
    used_d      = used_q;
    chords_d    = chords_q;
    fired_d     = fired_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          item_d   = in_data_i;
          addr_d   = '0;
          mods_d   = '0;
          used_d   = '0;
          chords_d = '0;
          fired_d  = '0;
          status_d = STS_OK;
          priority if (in_data_i.command == CMD_EVAL) begin
            state_d = ST_CHORD;
          end else if (in_data_i.command == CMD_BIND_MASK ||
                       in_data_i.command == CMD_BIND_SLOT) begin
            if (in_data_i.action_index >= 5'(NumActions)) begin
              status_d = STS_RANGE;
              state_d  = ST_FINISH;
            end else begin
              addr_d  = AddrW'(in_data_i.action_index);
              state_d = ST_BIND;
            end
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_CHORD: begin
        mods_d   = mods_q | ev.mods;
        used_d   = used_q | ev.used;
        chords_d = chords_q | ev.chords;
        if (ev.chord_fire) fired_d[addr_q] = 1'b1;
        if (addr_q == AddrLast) begin
          addr_d  = '0;
          state_d = ST_PLAIN;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      ST_PLAIN: begin
        if (ev.plain_fire) fired_d[addr_q] = 1'b1;
        if (addr_q == AddrLast) begin
          state_d = ST_FINISH;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      ST_BIND: begin
        if (!tbl_we) status_d = STS_SINGLE;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        // load the result once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d.action_mask = fired_q;
          out_d.chord_mask  = chords_q;
          out_d.status      = status_q;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      addr_q      <= '0;
      status_q    <= STS_OK;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      addr_q      <= addr_d;
      status_q    <= status_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    mods_q   <= mods_d;
    used_q   <= used_d;
    chords_q <= chords_d;
    fired_q  <= fired_d;
    out_q    <= out_d;
  end

`ifndef ASSERT_OFF
  // an error result carries no fired actions and no chords
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STS_OK) |->
      (out_data_o.action_mask == '0) && (out_data_o.chord_mask == '0))
    else $error("error result with non-zero masks");

  // a transfer in makes the block busy on the next cycle
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("not busy after input transfer");

  // the table is written only from the bind step
  a_write_in_bind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> (state_q == ST_BIND) && (addr_q <= AddrLast))
    else $error("table write outside bind step");
`endif

endmodule

[verif/tb.sv]
// testbench for the chord button action mapper: directed table, random commands, predictor
`timescale 1ns / 1ps

module tb;
  import cbam_pkg::*;

  // command code the block leaves unused
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int NumRandom   = 1250;
  localparam int QuietTail   = 150;
  localparam int DrainCycles = 64;

  // one row of the directed table: command, whether the answer is fixed, the answer
  typedef struct packed {
    cbam_in_t  item;
    logic      fixed;
    cbam_out_t want;
  } plan_row_t;

  localparam int DirectedRows = 23;
  localparam plan_row_t DirectedPlan [DirectedRows] = '{
    // evaluate right after reset: nothing is bound
    '{'{CMD_EVAL, 5'd31, 16'hffff, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      1'b1, '{23'h0, 16'h0, STS_OK}},
    // action index out of range on both bind commands
    '{'{CMD_BIND_MASK, 5'd23, 16'hffff, 16'hffff, 16'hffff, 1'b0, 16'h0000, 16'h0000},
      1'b1, '{23'h0, 16'h0, STS_RANGE}},
    '{'{CMD_BIND_SLOT, 5'd31, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0001, 16'h0002},
      1'b1, '{23'h0, 16'h0, STS_RANGE}},
    // button with two bits, modifier with two bits, button equal to modifier
    '{'{CMD_BIND_SLOT, 5'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0003, 16'h0000},
      1'b1, '{23'h0, 16'h0, STS_SINGLE}},
    '{'{CMD_BIND_SLOT, 5'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0001, 16'h8100},
      1'b1, '{23'h0, 16'h0, STS_SINGLE}},
    '{'{CMD_BIND_SLOT, 5'd0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h8000, 16'h8000},
      1'b1, '{23'h0, 16'h0, STS_SINGLE}},
    // unused command answers all zero and leaves the table alone
    '{'{CMD_UNUSED, 5'd0, 16'hffff, 16'hffff, 16'hffff, 1'b1, 16'hffff, 16'hffff},
      1'b1, '{23'h0, 16'h0, STS_OK}},
    // whole masks on the first and last action
    '{'{CMD_BIND_MASK, 5'd0, 16'h1234, 16'h0000, 16'hffff, 1'b1, 16'hffff, 16'hffff},
      1'b1, '{23'h0, 16'h0, STS_OK}},
    '{'{CMD_BIND_MASK, 5'd22, 16'h0000, 16'hffff, 16'h8001, 1'b0, 16'h0000, 16'h0000},
      1'b1, '{23'h0, 16'h0, STS_OK}},
    // chord slot, plain slot, modifier dropped with a zero button, chord on a high button
    '{'{CMD_BIND_SLOT, 5'd1, 16'hffff, 16'h0000, 16'h0000, 1'b0, 16'h0004, 16'h0008},
      1'b1, '{23'h0, 16'h0, STS_OK}},
    '{'{CMD_BIND_SLOT, 5'd2, 16'h0000, 16'h0000, 16'hffff, 1'b1, 16'h0010, 16'h0000},
      1'b1, '{23'h0, 16'h0, STS_OK}},
    '{'{CMD_BIND_SLOT, 5'd3, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0100},
      1'b1, '{23'h0, 16'h0, STS_OK}},
    '{'{CMD_BIND_SLOT, 5'd21, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h8000, 16'h0001},
      1'b1, '{23'h0, 16'h0, STS_OK}},
    // chord held, everything held, everything suppressed, button or modifier alone
    '{'{CMD_EVAL, 5'd0, 16'h000c, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      1'b0, '{23'h0, 16'h0, STS_OK}},
    '{'{CMD_EVAL, 5'd5, 16'hffff, 16'h0000, 16'hffff, 1'b1, 16'hffff, 16'hffff},
      1'b0, '{23'h0, 16'h0, STS_OK}},
    '{'{CMD_EVAL, 5'd0, 16'hffff, 16'hffff, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      1'b0, '{23'h0, 16'h0, STS_OK}},
    '{'{CMD_EVAL, 5'd0, 16'h0004, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      1'b0, '{23'h0, 16'h0, STS_OK}},
    '{'{CMD_EVAL, 5'd0, 16'h0008, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      1'b0, '{23'h0, 16'h0, STS_OK}},
    // replace a slot button that came from a whole mask
    '{'{CMD_BIND_SLOT, 5'd0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0200, 16'h0000},
      1'b1, '{23'h0, 16'h0, STS_OK}},
    '{'{CMD_EVAL, 5'd0, 16'h8001, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      1'b0, '{23'h0, 16'h0, STS_OK}},
    '{'{CMD_BIND_MASK, 5'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      1'b1, '{23'h0, 16'h0, STS_OK}},
    '{'{CMD_EVAL, 5'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      1'b0, '{23'h0, 16'h0, STS_OK}},
    '{'{CMD_EVAL, 5'd0, 16'hffff, 16'h7fff, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      1'b0, '{23'h0, 16'h0, STS_OK}}
  };

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall_o;
  cbam_in_t  in_data   = '0;
  logic      out_valid_o;
  logic      out_stall = 1'b0;
  cbam_out_t out_data_o;

  // predictor copy of the binding table
  logic [NumButtons-1:0] bound_tbl [NumActions];
  logic [NumButtons-1:0] prim_tbl  [NumActions];
  logic [NumButtons-1:0] sec_tbl   [NumActions];
  logic [NumButtons-1:0] mod_tbl   [2*NumActions];

  cbam_out_t expected_results [$];
  cbam_out_t next_result;
  int        error_count = 0;
  bit        idling_on   = 1'b1;

  chord_button_action_mapper u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // works out the answer to one command and applies its table update
  function automatic cbam_out_t map_buttons(input cbam_in_t item);
    cbam_out_t             res;
    logic [NumButtons-1:0] mods, used, avail, plain, m, k, both, old;
    int                    a;
    res = '0;
    case (item.command)
      CMD_EVAL: begin
        mods = '0;
        used = '0;
        // chord pass
        for (a = 0; a < NumActions; a++) begin
          for (int s = 0; s < 2; s++) begin
            m    = mod_tbl[2*a+s];
            k    = (s == 0) ? prim_tbl[a] : sec_tbl[a];
            both = m | k;
            mods |= m;
            if (m != '0 && k != '0 && (item.pressed & both) == both) begin
              res.action_mask[a] = 1'b1;
              used |= both;
            end
            if (m != '0 && (item.pressed & both) == both) res.chord_mask |= both;
          end
        end
        // plain pass on what is left
        avail = item.pressed & ~(mods | used | item.suppressed_mask);
        for (a = 0; a < NumActions; a++) begin
          plain = bound_tbl[a] & ~(prim_tbl[a] | sec_tbl[a]);
          if (mod_tbl[2*a] == '0) plain |= prim_tbl[a];
          if (mod_tbl[2*a+1] == '0) plain |= sec_tbl[a];
          if ((avail & plain) != '0) res.action_mask[a] = 1'b1;
        end
      end
      CMD_BIND_MASK, CMD_BIND_SLOT: begin
        a = int'(item.action_index);
        if (a >= NumActions) begin
          res.status = STS_RANGE;
        end else if (item.command == CMD_BIND_MASK) begin
          // slots take the two lowest set buttons
          bound_tbl[a]   = item.new_mask;
          prim_tbl[a]    = '0;
          sec_tbl[a]     = '0;
          mod_tbl[2*a]   = '0;
          mod_tbl[2*a+1] = '0;
          for (int b = 0; b < NumButtons; b++) begin
            if (item.new_mask[b]) begin
              if (prim_tbl[a] == '0) prim_tbl[a][b] = 1'b1;
              else if (sec_tbl[a] == '0) sec_tbl[a][b] = 1'b1;
            end
          end
        end else if ($countones(item.slot_button) > 1 || $countones(item.slot_modifier) > 1 ||
                     (item.slot_button != '0 && item.slot_button == item.slot_modifier)) begin
          res.status = STS_SINGLE;
        end else begin
          old = item.slot_select ? sec_tbl[a] : prim_tbl[a];
          mod_tbl[2*a+int'(item.slot_select)] = (item.slot_button == '0) ? '0 :
                                                 item.slot_modifier;
          if (item.slot_select) sec_tbl[a] = item.slot_button;
          else prim_tbl[a] = item.slot_button;
          bound_tbl[a] = (bound_tbl[a] & ~old) | prim_tbl[a] | sec_tbl[a];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [NumButtons-1:0] one_hot();
    return 16'h1 << $urandom_range(NumButtons-1);
  endfunction

  // random command: mostly well-formed binds and evaluates, some noise
  function automatic cbam_in_t random_command();
    cbam_in_t              item;
    logic [NumButtons-1:0] btn, mdf;
    int                    pick;
    item.command         = CMD_EVAL;
    item.action_index    = 5'($urandom_range(31));
    item.pressed         = 16'($urandom);
    item.suppressed_mask = 16'($urandom);
    item.new_mask        = 16'($urandom);
    item.slot_select     = 1'($urandom_range(1));
    item.slot_button     = 16'($urandom);
    item.slot_modifier   = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) begin
      // a few held buttons, all of them, or noise
      case ($urandom_range(3))
        0: item.pressed = '1;
        1: item.pressed = 16'($urandom);
        default: begin
          item.pressed = '0;
          repeat ($urandom_range(5, 1)) item.pressed |= one_hot();
        end
      endcase
      if ($urandom_range(2) != 0) item.suppressed_mask = '0;
    end else if (pick < 60) begin
      item.command = CMD_BIND_MASK;
      if ($urandom_range(15) != 0) item.action_index = 5'($urandom_range(NumActions-1));
      if ($urandom_range(1) != 0) item.new_mask = one_hot() | one_hot() | one_hot();
    end else if (pick < 95) begin
      item.command = CMD_BIND_SLOT;
      if ($urandom_range(15) != 0) item.action_index = 5'($urandom_range(NumActions-1));
      if ($urandom_range(9) != 0) begin
        btn = ($urandom_range(7) == 0) ? '0 : one_hot();
        mdf = ($urandom_range(1) == 0) ? '0 : one_hot();
        if (mdf == btn) mdf = {mdf[NumButtons-2:0], mdf[NumButtons-1]};
        item.slot_button   = btn;
        item.slot_modifier = mdf;
      end
    end else begin
      item.command = CMD_UNUSED;
    end
    return item;
  endfunction

  function automatic int idle_gap();
    if (!idling_on || $urandom_range(3) != 0) return 0;
    return $urandom_range(11, 1);
  endfunction

  // append one expected result at the back of the queue
  task automatic queue_result(input cbam_out_t res);
    expected_results = {expected_results, res};
  endtask

  // one input transfer, after an optional idle gap
  task automatic send_command(input cbam_in_t item, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // stimulus
  initial begin
    cbam_out_t predicted;
    cbam_in_t  item;
    for (int a = 0; a < NumActions; a++) begin
      bound_tbl[a]   = '0;
      prim_tbl[a]    = '0;
      sec_tbl[a]     = '0;
      mod_tbl[2*a]   = '0;
      mod_tbl[2*a+1] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < DirectedRows; i++) begin
      send_command(DirectedPlan[i].item, idle_gap());
      predicted = map_buttons(DirectedPlan[i].item);
      queue_result(DirectedPlan[i].fixed ? DirectedPlan[i].want : predicted);
    end

    // random commands, idling switched per stretch, none in the tail
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 100 == 0) idling_on = ($urandom_range(3) != 0);
      if (i >= NumRandom - QuietTail) idling_on = 1'b0;
      item = random_command();
      send_command(item, idle_gap());
      queue_result(map_buttons(item));
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("chord_button_action_mapper test passed");
    end else begin
      $display("chord_button_action_mapper test failed");
    end
    $finish;
  end

  // output stall bursts
  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      if (idling_on && rst_ni && $urandom_range(5) == 0) begin
        hold = $urandom_range(11, 1);
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
    end
  end

  // compare each output transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_data_o.action_mask), 32'h0);
      end else begin
        next_result = expected_results.pop_front();
        if (out_data_o.action_mask !== next_result.action_mask)
          report_mismatch("action_mask", 32'(out_data_o.action_mask),
                          32'(next_result.action_mask));
        if (out_data_o.chord_mask !== next_result.chord_mask)
          report_mismatch("chord_mask", 32'(out_data_o.chord_mask),
                          32'(next_result.chord_mask));
        if (out_data_o.status !== next_result.status)
          report_mismatch("status", 32'(out_data_o.status), 32'(next_result.status));
      end
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("chord_button_action_mapper test failed");
    $finish;
  end

endmodule
